>>> src/rwu_pkg.sv
// shared types and constants for the rprop weight update block
`default_nettype none

package rwu_pkg;

  localparam int unsigned Features   = 1024;
  localparam int unsigned IdxW       = $clog2(Features);
  localparam int unsigned DivW       = 48;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic {
    OP_INIT   = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CFG_REG_STRENGTH = 3'd0,
    CFG_GROW_RATE    = 3'd1,
    CFG_SHRINK_RATE  = 3'd2,
    CFG_STEP_FLOOR   = 3'd3,
    CFG_STEP_CEILING = 3'd4,
    CFG_STEP_START   = 3'd5,
    CFG_WEIGHT_FLOOR = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    op_e                op;
    logic [9:0]         feature_index;
    logic signed [31:0] gradient_sum;
    logic signed [31:0] weight_in;
    logic [30:0]        score_sum;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic               div_fault;
  } out_item_t;

  // step and weight settings used by the update side
  typedef struct packed {
    logic [15:0] grow_rate;
    logic [15:0] shrink_rate;
    logic [30:0] step_floor;
    logic [30:0] step_ceiling;
    logic [30:0] step_start;
    logic [30:0] weight_floor;
  } step_cfg_t;

  // classified item passed from the front part to the update side
  typedef struct packed {
    op_e                op;
    logic [IdxW-1:0]    idx;
    logic signed [31:0] weight;
    logic signed [31:0] grad;
    logic               fault;
  } work_t;

  typedef struct packed {
    logic signed [31:0] last_gradient;
    logic [31:0]        step_size;
    logic signed [31:0] last_weight;
  } entry_t;

endpackage

`default_nettype wire

>>> src/rwu_front.sv
// front part: accepts items, regularizes the gradient through a pipelined divider
`default_nettype none

module rwu_front import rwu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [30:0] reg_strength_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output work_t            push_data_o
);

  typedef struct packed {
    op_e                op;
    logic [IdxW-1:0]    idx;
    logic signed [31:0] weight;
    logic signed [31:0] grad;
    logic               reg_on;
    logic               zero_div;
    logic [30:0]        divisor;
    logic [DivW-1:0]    nq;
    logic [30:0]        rem;
    logic [DivW-1:0]    prod;
  } fst_t;

  localparam logic signed [49:0] SatHi = 50'sd2147483647;
  localparam logic signed [49:0] SatLo = -50'sd2147483648;

  logic               adv;
  logic               accept;
  fst_t               st_q [DivW+1];
  logic [DivW:0]      vld_q;
  logic [31:0]        gmag;
  logic [31:0]        wmag0;
  logic [62:0]        prod_full;
  logic [DivW-1:0]    prod0;

  assign adv        = !q_full_i;
  assign accept     = in_valid_i && adv;
  assign in_stall_o = !adv;

  assign gmag = in_data_i.gradient_sum[31] ? 32'(-in_data_i.gradient_sum)
                                           : 32'(in_data_i.gradient_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DivW-1:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0].op       <= in_data_i.op;
      st_q[0].idx      <= in_data_i.feature_index[IdxW-1:0];
      st_q[0].weight   <= in_data_i.weight_in;
      st_q[0].grad     <= in_data_i.gradient_sum;
      st_q[0].reg_on   <= (reg_strength_i != '0);
      st_q[0].zero_div <= (in_data_i.score_sum == '0);
      st_q[0].divisor  <= in_data_i.score_sum;
      st_q[0].nq       <= {gmag, 16'b0};
      st_q[0].rem      <= '0;
      st_q[0].prod     <= '0;
    end
  end

  // l2 term magnitude, taken once in the first step
  assign wmag0     = st_q[0].weight[31] ? 32'(-st_q[0].weight) : 32'(st_q[0].weight);
  assign prod_full = 63'(reg_strength_i) * 63'(wmag0);
  assign prod0     = prod_full[62:15];

  // one quotient bit per stage
  for (genvar k = 0; k < DivW; k++) begin : g_div
    fst_t        nx;
    logic [31:0] trial;
    logic        ge;
    always_comb begin
      nx    = st_q[k];
      trial = {st_q[k].rem, st_q[k].nq[DivW-1]};
      ge    = trial >= {1'b0, st_q[k].divisor};
      nx.rem = ge ? 31'(trial - {1'b0, st_q[k].divisor}) : trial[30:0];
      nx.nq  = {st_q[k].nq[DivW-2:0], ge};
      if (k == 0) begin
        nx.prod = prod0;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k+1] <= nx;
      end
    end
  end

  // quotient minus l2 term, saturated
  logic signed [49:0] quo_s;
  logic signed [49:0] reg_s;
  logic signed [49:0] diff;
  logic signed [31:0] g_reg;

  always_comb begin
    quo_s = st_q[DivW].grad[31] ? -$signed({2'b0, st_q[DivW].nq})
                                : $signed({2'b0, st_q[DivW].nq});
    if (st_q[DivW].zero_div) begin
      quo_s = '0;
    end
    reg_s = st_q[DivW].weight[31] ? -$signed({2'b0, st_q[DivW].prod})
                                  : $signed({2'b0, st_q[DivW].prod});
    diff  = quo_s - reg_s;
    if (diff > SatHi) begin
      g_reg = 32'sh7fffffff;
    end else if (diff < SatLo) begin
      g_reg = 32'sh80000000;
    end else begin
      g_reg = diff[31:0];
    end
  end

  assign push_o = adv && vld_q[DivW];

  always_comb begin
    push_data_o.op     = st_q[DivW].op;
    push_data_o.idx    = st_q[DivW].idx;
    push_data_o.weight = st_q[DivW].weight;
    push_data_o.grad   = st_q[DivW].reg_on ? g_reg : st_q[DivW].grad;
    push_data_o.fault  = (st_q[DivW].op == OP_UPDATE) && st_q[DivW].reg_on &&
                         st_q[DivW].zero_div;
  end

endmodule

`default_nettype wire

>>> src/rwu_queue.sv
// short queue between the front part and the update side
`default_nettype none

module rwu_queue import rwu_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire work_t push_data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       head_valid_o,
  output work_t      head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  work_t           buf_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;

  assign full_o       = (count_q == CntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue push while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_valid_o)
    else $error("queue pop while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

`default_nettype wire

>>> src/rwu_back.sv
// update side: per-feature state memory, step adaptation and weight step
`default_nettype none

module rwu_back import rwu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire step_cfg_t cfg_i,
  input  wire logic      head_valid_i,
  input  wire work_t     head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  entry_t    mem [Features];
  logic      adv;
  logic      r_valid_q;
  work_t     r_q;
  entry_t    rd_q;
  logic      fwd_q;
  entry_t    fwd_e_q;
  logic      out_valid_q;
  out_item_t out_q;
  entry_t    cur;
  entry_t    nxt_e;
  out_item_t res;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      r_valid_q   <= pop_o;
      fwd_q       <= r_valid_q && (r_q.idx == head_i.idx);
      out_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q     <= head_i;
      rd_q    <= mem[head_i.idx];
      fwd_e_q <= nxt_e;
      out_q   <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && r_valid_q) begin
      mem[r_q.idx] <= nxt_e;
    end
  end

  assign cur = fwd_q ? fwd_e_q : rd_q;

  logic               g_nz, lg_nz, agree_pos, agree_neg;
  logic [15:0]        rate;
  logic [47:0]        sprod;
  logic [35:0]        scaled;
  logic [35:0]        clamped;
  logic [31:0]        step_new;
  logic signed [33:0] wsum;
  logic signed [31:0] w_step;
  logic signed [31:0] w_new;
  logic signed [31:0] lw_new;
  logic [32:0]        w_abs;

  always_comb begin
    g_nz      = (r_q.grad != '0);
    lg_nz     = (cur.last_gradient != '0);
    agree_pos = g_nz && lg_nz && (r_q.grad[31] == cur.last_gradient[31]);
    agree_neg = g_nz && lg_nz && (r_q.grad[31] != cur.last_gradient[31]);
    rate      = agree_pos ? cfg_i.grow_rate : cfg_i.shrink_rate;
    sprod     = 48'(cur.step_size) * 48'(rate);
    scaled    = (agree_pos || agree_neg) ? sprod[47:12] : {4'b0, cur.step_size};
    clamped   = scaled;
    if (clamped < 36'(cfg_i.step_floor)) begin
      clamped = 36'(cfg_i.step_floor);
    end
    if (clamped > 36'(cfg_i.step_ceiling)) begin
      clamped = 36'(cfg_i.step_ceiling);
    end
    step_new = clamped[31:0];

    // move against or with the gradient sign, saturating
    if (r_q.grad[31]) begin
      wsum = 34'(r_q.weight) - $signed({2'b0, step_new});
    end else begin
      wsum = 34'(r_q.weight) + $signed({2'b0, step_new});
    end
    if (wsum > 34'sd2147483647) begin
      w_step = 32'sh7fffffff;
    end else if (wsum < -34'sd2147483648) begin
      w_step = 32'sh80000000;
    end else begin
      w_step = wsum[31:0];
    end

    if (agree_neg) begin
      w_new  = cur.last_weight;
      lw_new = cur.last_weight;
    end else if (g_nz) begin
      w_new  = w_step;
      lw_new = r_q.weight;
    end else begin
      w_new  = r_q.weight;
      lw_new = cur.last_weight;
    end

    w_abs = w_new[31] ? 33'(-$signed({w_new[31], w_new})) : 33'({1'b0, w_new});
    if (w_abs < 33'(cfg_i.weight_floor)) begin
      w_new = '0;
    end

    if (r_q.op == OP_INIT) begin
      nxt_e.last_gradient = '0;
      nxt_e.step_size     = {1'b0, cfg_i.step_start};
      nxt_e.last_weight   = r_q.weight;
      res.weight_out      = r_q.weight;
      res.div_fault       = 1'b0;
    end else begin
      nxt_e.last_gradient = r_q.grad;
      nxt_e.step_size     = step_new;
      nxt_e.last_weight   = lw_new;
      res.weight_out      = w_new;
      res.div_fault       = r_q.fault;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> src/rprop_weight_update_top.sv
// top level of the rprop weight update block with weight backtracking
`default_nettype none

// One item enters per clock when the internal queue has room; each item gives
// exactly one result. From input transfer to result an item passes through
// one input stage, 48 stages of the restoring divider (one quotient bit each)
// that forms the regularized gradient, the four-entry queue, then a memory
// read register and an update into the output register.
// Throughput is one item per cycle while the output is not stalled; the update
// side reads the per-feature state in the stage before the update and forwards
// the entry just written, so the same feature may follow itself back to back.
// The state memory holds 1024 entries and is not cleared: update a feature only after an init item for it.
module rprop_weight_update_top import rwu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  // item input
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  // result output
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o,
  // register writes
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [30:0] reg_strength_q;
  step_cfg_t   step_cfg_q;
  logic        q_full;
  logic        push;
  work_t       push_data;
  logic        pop;
  logic        head_valid;
  work_t       head;

  // registers accept a transfer every cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_strength_q          <= '0;
      step_cfg_q.grow_rate    <= 16'd4915;
      step_cfg_q.shrink_rate  <= 16'd2048;
      step_cfg_q.step_floor   <= '0;
      step_cfg_q.step_ceiling <= 31'd3276800;
      step_cfg_q.step_start   <= 31'd6554;
      step_cfg_q.weight_floor <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_REG_STRENGTH: reg_strength_q          <= cfg_data_i[30:0];
        CFG_GROW_RATE:    step_cfg_q.grow_rate    <= cfg_data_i[15:0];
        CFG_SHRINK_RATE:  step_cfg_q.shrink_rate  <= cfg_data_i[15:0];
        CFG_STEP_FLOOR:   step_cfg_q.step_floor   <= cfg_data_i[30:0];
        CFG_STEP_CEILING: step_cfg_q.step_ceiling <= cfg_data_i[30:0];
        CFG_STEP_START:   step_cfg_q.step_start   <= cfg_data_i[30:0];
        CFG_WEIGHT_FLOOR: step_cfg_q.weight_floor <= cfg_data_i[30:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  // front: input transfer and gradient regularization
  rwu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .reg_strength_i (reg_strength_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  // decoupling queue
  rwu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back: state read, step adaptation, weight step, result register
  rwu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (step_cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_rwu_checker.sv
// checker for the rprop weight update block: predicts results and compares them
`timescale 1ns / 100ps

module tb_rwu_checker import rwu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire in_item_t    in_data_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire out_item_t   out_data_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  logic [30:0] reg_strength_q;
  logic [15:0] grow_q, shrink_q;
  logic [30:0] step_floor_q, step_ceiling_q, step_start_q, weight_floor_q;

  longint feat_last_grad [Features];
  longint feat_step [Features];
  longint feat_last_weight [Features];

  out_item_t weight_queue[$];

  assign pending_o = weight_queue.size();

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int sgn(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  task automatic predict_weight(input in_item_t it);
    int unsigned fi;
    longint g, w, s, q, r, stp, mag, prod, a;
    int agree;
    out_item_t res;
    fi = it.feature_index % Features;
    g = it.gradient_sum;
    w = it.weight_in;
    s = it.score_sum;
    res.div_fault = 1'b0;
    if (it.op == OP_INIT) begin
      feat_last_weight[fi] = w;
      feat_step[fi] = step_start_q;
      feat_last_grad[fi] = 0;
      res.weight_out = w[31:0];
      weight_queue.insert(weight_queue.size(), res);
      return;
    end
    if (reg_strength_q != 0) begin
      q = 0;
      mag = (w < 0) ? -w : w;
      // product fits in 63 bits: 31 + 32 bits
      prod = (longint'(reg_strength_q) * mag) >>> 15;
      if (s == 0) res.div_fault = 1'b1;
      else q = (g * 65536) / s;
      r = (w < 0) ? -prod : prod;
      g = clamp32(q - r);
    end
    agree = sgn(g) * sgn(feat_last_grad[fi]);
    stp = feat_step[fi] & 64'hFFFF_FFFF;
    if (agree > 0) stp = (stp * grow_q) >>> 12;
    else if (agree < 0) stp = (stp * shrink_q) >>> 12;
    if (stp < step_floor_q) stp = step_floor_q;
    if (stp > step_ceiling_q) stp = step_ceiling_q;
    feat_step[fi] = stp;
    feat_last_grad[fi] = g;
    if (agree >= 0) begin
      if (g > 0) begin
        feat_last_weight[fi] = w;
        w = clamp32(w + stp);
      end else if (g < 0) begin
        feat_last_weight[fi] = w;
        w = clamp32(w - stp);
      end
    end else begin
      // sign flip restores the previous weight
      w = feat_last_weight[fi];
    end
    a = (w < 0) ? -w : w;
    if (a < weight_floor_q) w = 0;
    res.weight_out = w[31:0];
    weight_queue.insert(weight_queue.size(), res);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_res;
    if (!rst_ni) begin
      reg_strength_q <= '0;
      grow_q <= 16'd4915;
      shrink_q <= 16'd2048;
      step_floor_q <= '0;
      step_ceiling_q <= 31'd3276800;
      step_start_q <= 31'd6554;
      weight_floor_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_REG_STRENGTH: reg_strength_q <= cfg_data_i[30:0];
          CFG_GROW_RATE: grow_q <= cfg_data_i[15:0];
          CFG_SHRINK_RATE: shrink_q <= cfg_data_i[15:0];
          CFG_STEP_FLOOR: step_floor_q <= cfg_data_i[30:0];
          CFG_STEP_CEILING: step_ceiling_q <= cfg_data_i[30:0];
          CFG_STEP_START: step_start_q <= cfg_data_i[30:0];
          CFG_WEIGHT_FLOOR: weight_floor_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_weight(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (weight_queue.size() == 0) begin
          report_mismatch("unexpected result", out_data_i.weight_out, 0);
        end else begin
          exp_res = weight_queue.pop_front();
          if (out_data_i.weight_out !== exp_res.weight_out)
            report_mismatch("weight_out", out_data_i.weight_out, exp_res.weight_out);
          if (out_data_i.div_fault !== exp_res.div_fault)
            report_mismatch("div_fault", out_data_i.div_fault, exp_res.div_fault);
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// testbench top for the rprop weight update block: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_top;
  import rwu_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 80;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, pending;

  // receiver behavior knobs
  bit hold_off;     // long receiver hold-off in progress
  bit calm_out;     // no random stalls on the output

  // features that have seen an init transfer
  bit seeded [Features];
  int unsigned seeded_list[$];

  rprop_weight_update_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  tb_rwu_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stall process: random gaps, plus long hold-off when asked
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (calm_out) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n == 0) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on any channel
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // one input transfer, then possibly a gap; valid stays high for back to back items
  task automatic send_item(input in_item_t it);
    int g;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.op == OP_INIT && !seeded[it.feature_index]) begin
      seeded[it.feature_index] = 1'b1;
      seeded_list.insert(seeded_list.size(), it.feature_index);
    end
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // items still in flight behind the last result
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t make_item(op_e op, int unsigned fi, logic [31:0] g,
                                         logic [31:0] w, logic [30:0] s);
    in_item_t it;
    it.op = op;
    it.feature_index = fi[9:0];
    it.gradient_sum = g;
    it.weight_in = w;
    it.score_sum = s;
    return it;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 3) - 1;
      3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_score();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(1, 65536));
      default: return 31'($urandom);
    endcase
  endfunction

  // random item: mostly updates on seeded features, some inits
  function automatic in_item_t rand_item();
    int unsigned fi;
    if (seeded_list.size() == 0 || $urandom_range(0, 99) < 18) begin
      fi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
      return make_item(OP_INIT, fi, rand_val(), rand_val(), rand_score());
    end
    fi = seeded_list[$urandom_range(0, seeded_list.size() - 1)];
    return make_item(OP_UPDATE, fi, rand_val(), rand_val(), rand_score());
  endfunction

  task automatic random_config();
    write_reg(CFG_REG_STRENGTH, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 1 << 17));
    write_reg(CFG_GROW_RATE, $urandom_range(0, 65535));
    write_reg(CFG_SHRINK_RATE, $urandom_range(0, 8192));
    write_reg(CFG_STEP_FLOOR, $urandom_range(0, 1 << 12));
    write_reg(CFG_STEP_CEILING, $urandom_range(0, 1 << 24));
    write_reg(CFG_STEP_START, $urandom_range(0, 1 << 20));
    write_reg(CFG_WEIGHT_FLOOR, $urandom_range(0, 1 << 10));
  endtask

  initial begin
    in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_off = 1'b0;
    calm_out = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, both ops, flips, saturation, zero score sum
    send_item(make_item(OP_INIT, 0, 0, 32'h7FFF_FFF0, 0));
    send_item(make_item(OP_INIT, 1023, 32'h8000_0000, 32'h8000_0010, 31'h7FFF_FFFF));
    send_item(make_item(OP_INIT, 5, 32'hFFFF_FFFF, 0, 1));
    send_item(make_item(OP_UPDATE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFF0, 0));   // saturate up
    send_item(make_item(OP_UPDATE, 0, 32'h0001_0000, 32'h7FFF_FFF0, 0));   // agree, grow
    send_item(make_item(OP_UPDATE, 0, 32'hFFFF_0000, 32'h0000_1000, 0));   // flip, restore
    send_item(make_item(OP_UPDATE, 0, 0, 32'h0000_2000, 0));               // zero gradient
    send_item(make_item(OP_UPDATE, 1023, 32'h8000_0000, 32'h8000_0010, 0)); // saturate down
    send_item(make_item(OP_UPDATE, 1023, 32'h0000_0001, 32'h8000_0010, 0));
    send_item(make_item(OP_UPDATE, 5, 32'h0000_0100, 32'h0000_0010, 0));
    send_item(make_item(OP_UPDATE, 5, 32'h0000_0100, 32'hFFFF_FFF0, 0));   // same feature again
    wait_drained();

    // regularisation on, including a zero score sum and tiny weights
    write_reg(CFG_REG_STRENGTH, 32'h7FFF_FFFF);
    write_reg(CFG_WEIGHT_FLOOR, 32'h0000_4000);
    send_item(make_item(OP_INIT, 7, 0, 32'h0001_0000, 0));
    send_item(make_item(OP_UPDATE, 7, 32'h0001_0000, 32'h0001_0000, 0));   // divide by zero
    send_item(make_item(OP_UPDATE, 7, 32'h7FFF_FFFF, 32'h8000_0000, 1));
    send_item(make_item(OP_UPDATE, 7, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_item(make_item(OP_UPDATE, 7, 32'h0000_0010, 32'h0000_0100, 31'h0001_0000));
    wait_drained();

    // extreme rates and step limits, floor above ceiling
    write_reg(CFG_REG_STRENGTH, 0);
    write_reg(CFG_GROW_RATE, 32'hFFFF);
    write_reg(CFG_SHRINK_RATE, 0);
    write_reg(CFG_STEP_FLOOR, 32'h7FFF_FFFF);
    write_reg(CFG_STEP_CEILING, 32'h0010_0000);
    write_reg(CFG_STEP_START, 32'h7FFF_FFFF);
    write_reg(CFG_WEIGHT_FLOOR, 0);
    send_item(make_item(OP_INIT, 9, 0, 0, 0));
    send_item(make_item(OP_UPDATE, 9, 32'h0000_0001, 0, 0));
    send_item(make_item(OP_UPDATE, 9, 32'h0000_0001, 0, 0));
    send_item(make_item(OP_UPDATE, 9, 32'hFFFF_FFFF, 0, 0));
    wait_drained();
    write_reg(CFG_STEP_FLOOR, 0);
    write_reg(CFG_STEP_CEILING, 32'h7FFF_FFFF);
    write_reg(CFG_STEP_START, 0);

    // receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    repeat (60) send_item(rand_item());

    // random phases with fresh settings between them
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph == 3) begin
        write_reg(CFG_GROW_RATE, 4915);
        write_reg(CFG_SHRINK_RATE, 2048);
        write_reg(CFG_STEP_CEILING, 3276800);
      end else begin
        random_config();
      end
      calm_out = (ph == 2);
      for (int k = 0; k < 150; k++) begin
        it = rand_item();
        send_item(it);
      end
    end
    calm_out = 1'b0;

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
